@@ hdl/dsbs_pkg.sv @@
// Shared types and constants for the descriptor-driven byte swapper.
package dsbs_pkg;

    // Two-bit group codes taken from the descriptor
    localparam logic [1:0] CODE_PASS  = 2'd0;
    localparam logic [1:0] CODE_SWAP2 = 2'd1;
    localparam logic [1:0] CODE_REV4  = 2'd2;
    localparam logic [1:0] CODE_BAD   = 2'd3;
    localparam logic [1:0] CODE_MASK  = 2'h3;

    // Configuration register indexes
    localparam int          CFG_INDEX_W       = 2;
    localparam logic [1:0]  CFG_SWAP_CODES    = 2'd0;
    localparam logic [1:0]  CFG_RECORD_BYTES  = 2'd1;
    localparam logic [1:0]  CFG_RECORD_COUNT  = 2'd2;

    // Most results one input byte can release, and default result queue depth
    localparam int BURST_MAX     = 4;
    localparam int BURST_NUM_W   = $clog2(BURST_MAX + 1);
    localparam int BURST_IDX_W   = $clog2(BURST_MAX);
    localparam int QUEUE_DEPTH_D = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       eor;
        logic       eorun;
        logic       bad;
    } result_t;

    typedef struct packed {
        result_t [BURST_MAX-1:0]  res;
        logic [BURST_NUM_W-1:0]   num;
    } step_out_t;

endpackage

@@ hdl/dsbs_step.sv @@
// Record/group tracking state and the per-byte swap decision.
module dsbs_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          in_byte,
    input  logic [31:0]         swap_codes,
    input  logic [15:0]         record_bytes,
    input  logic [15:0]         record_count,
    output dsbs_pkg::step_out_t step_out
);
    import dsbs_pkg::*;

    logic [31:0] code_shift_reg, code_shift_next;
    logic [15:0] byte_position_reg, byte_position_next;
    logic [15:0] records_done_reg, records_done_next;
    logic [2:0]  hold_fill_reg, hold_fill_next;
    logic [1:0]  group_kind_reg, group_kind_next;
    logic        bad_flag_reg, bad_flag_next;
    logic [7:0]  group_hold_reg [4];
    logic [7:0]  group_hold_next [4];

    logic [15:0] rb, rc, pos1, rd1;
    logic [31:0] cs0;
    logic [2:0]  hf0, hf1, glen;
    logic [1:0]  code;
    logic        start, bf0, eor, eorun;

    always_comb
    begin
        rb    = (record_bytes == '0) ? 16'd1 : record_bytes;
        rc    = (record_count == '0) ? 16'd1 : record_count;
        start = (byte_position_reg == '0);
        cs0   = start ? swap_codes : code_shift_reg;
        hf0   = start ? 3'd0 : hold_fill_reg;
        bf0   = (start && records_done_reg == '0) ? 1'b0 : bad_flag_reg;
        code  = cs0[1:0] & CODE_MASK;

        // Pick up the next code at a group start; a bad code ends swapping for the record
        code_shift_next = cs0;
        group_kind_next = group_kind_reg;
        bad_flag_next   = bf0;
        if (hf0 == 3'd0)
        begin
            if (code == CODE_BAD)
            begin
                bad_flag_next   = 1'b1;
                code_shift_next = '0;
                group_kind_next = CODE_PASS;
            end
            else
            begin
                code_shift_next = cs0 >> 2;
                group_kind_next = code;
            end
        end

        for (int i = 0; i < 4; i++)
        begin
            group_hold_next[i] = (hf0[1:0] == 2'(i)) ? in_byte : group_hold_reg[i];
        end

        hf1   = hf0 + 3'd1;
        pos1  = byte_position_reg + 16'd1;
        rd1   = records_done_reg + 16'd1;
        eor   = (pos1 >= rb);
        eorun = eor && (rd1 >= rc);

        byte_position_next = eor ? 16'd0 : pos1;
        records_done_next  = eor ? (eorun ? 16'd0 : rd1) : records_done_reg;

        glen = (group_kind_next == CODE_REV4) ? 3'd4 : 3'd2;

        step_out       = '0;
        hold_fill_next = hf1;
        if (group_kind_next == CODE_PASS)
        begin
            step_out.num         = BURST_NUM_W'(1);
            step_out.res[0].data = in_byte;
            if (hf1 >= glen || eor)
            begin
                hold_fill_next = 3'd0;
            end
        end
        else if (hf1 >= glen)
        begin
            // Full group: emit held bytes in reverse order
            step_out.num = BURST_NUM_W'(glen);
            for (int k = 0; k < BURST_MAX; k++)
            begin
                step_out.res[k].data = (group_kind_next == CODE_REV4) ?
                    group_hold_next[2'(3 - k)] : group_hold_next[2'(1 - k)];
            end
            hold_fill_next = 3'd0;
        end
        else if (eor)
        begin
            // Group cut short by the record end: flush in arrival order
            step_out.num = BURST_NUM_W'(hf1);
            for (int k = 0; k < BURST_MAX; k++)
            begin
                step_out.res[k].data = group_hold_next[k];
            end
            hold_fill_next = 3'd0;
        end

        for (int k = 0; k < BURST_MAX; k++)
        begin
            step_out.res[k].eor   = eor && (BURST_NUM_W'(k) == step_out.num - 1'b1);
            step_out.res[k].eorun = eorun && (BURST_NUM_W'(k) == step_out.num - 1'b1);
            step_out.res[k].bad   = bad_flag_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_shift_reg    <= '0;
            byte_position_reg <= '0;
            records_done_reg  <= '0;
            hold_fill_reg     <= '0;
            group_kind_reg    <= CODE_PASS;
            bad_flag_reg      <= 1'b0;
        end
        else if (advance)
        begin
            code_shift_reg    <= code_shift_next;
            byte_position_reg <= byte_position_next;
            records_done_reg  <= records_done_next;
            hold_fill_reg     <= hold_fill_next;
            group_kind_reg    <= group_kind_next;
            bad_flag_reg      <= bad_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            group_hold_reg <= group_hold_next;
        end
    end

endmodule

@@ hdl/descriptor_struct_byte_swapper_top.sv @@
// Top level of the descriptor-driven byte swapper: config registers and result queue.
// Output path: a pass-through byte enters the result queue on its input transfer;
//   a swapped group enters with its last byte and drains one byte a cycle under m_tready.
// Throughput: one byte per cycle in and out while neither side stalls, set by the state
//   update and the one-entry-per-cycle queue head; s_tready drops while the queue holds
//   more than QUEUE_DEPTH - 4 results, so a burst of four always fits.
// Reset (rst_n, async active low): clears group/record state and the queue count and
//   loads the register defaults (no swap codes, one-byte records, one-record runs).
module descriptor_struct_byte_swapper_top #(
    parameter int QUEUE_DEPTH = dsbs_pkg::QUEUE_DEPTH_D
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] in_byte
    // Output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] out_byte
    output logic                              m_tlast,   // end_of_record
    output logic [1:0]                        m_tuser,   // [0] end_of_run, [1] bad_code_seen
    // Configuration write port
    input  logic                              cfg_wen,
    input  logic [dsbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [31:0]                       cfg_wdata
);
    import dsbs_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [31:0] swap_codes_reg;
    logic [15:0] record_bytes_reg;
    logic [15:0] record_count_reg;

    result_t     queue_reg [QUEUE_DEPTH];
    result_t     queue_next [QUEUE_DEPTH];
    logic [CW-1:0] count_reg, count_next, base, off;

    step_out_t   step_out;
    logic        push, pop;

    // Config registers: index beyond the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_codes_reg   <= 32'd0;
            record_bytes_reg <= 16'd1;
            record_count_reg <= 16'd1;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_SWAP_CODES:   swap_codes_reg   <= cfg_wdata;
                CFG_RECORD_BYTES: record_bytes_reg <= cfg_wdata[15:0];
                CFG_RECORD_COUNT: record_count_reg <= cfg_wdata[15:0];
                default:          ;
            endcase
        end
    end

    // Accept a byte whenever a worst-case burst still fits in the queue
    assign s_tready = (count_reg <= CW'(QUEUE_DEPTH - BURST_MAX));
    assign push     = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    dsbs_step u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (push),
        .in_byte      (s_tdata),
        .swap_codes   (swap_codes_reg),
        .record_bytes (record_bytes_reg),
        .record_count (record_count_reg),
        .step_out     (step_out)
    );

    // Shift queue: head at entry 0; advance on a transfer out, append the burst behind
    always_comb
    begin
        queue_next = queue_reg;
        base       = count_reg - CW'(pop);
        off        = '0;
        if (pop)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                queue_next[i] = queue_reg[i + 1];
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            off = CW'(i) - base;
            if (push && CW'(i) >= base && off < CW'(step_out.num))
            begin
                queue_next[i] = step_out.res[off[BURST_IDX_W-1:0]];
            end
        end
        count_next = base + (push ? CW'(step_out.num) : CW'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        queue_reg <= queue_next;
    end

    assign m_tvalid   = (count_reg != '0);
    assign m_tdata    = queue_reg[0].data;
    assign m_tlast    = queue_reg[0].eor;
    assign m_tuser[0] = queue_reg[0].eorun;
    assign m_tuser[1] = queue_reg[0].bad;

endmodule

@@ hdl/dsbs_checker.sv @@
// Port-level checks for the byte swapper, bound to the top level.
module dsbs_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [7:0]                        s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [7:0]                        m_tdata,
    input  logic                              m_tlast,
    input  logic [1:0]                        m_tuser
);

    // Hold a stalled output transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
        && $stable(m_tuser))
        else $error("stalled output transfer changed");

    // Hold a stalled input transfer
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("stalled input transfer changed");

    // Run end always falls on a record end
    a_run_on_record: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("end_of_run without end_of_record");

    // Backpressure only while results are queued
    a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty queue");

    // Queue starts empty out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind descriptor_struct_byte_swapper_top dsbs_checker u_dsbs_checker (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the descriptor-driven byte swapper top level.
module tb_top;
    import dsbs_pkg::*;

    localparam int         HALF_PERIOD     = 6;
    localparam int         RESET_CYCLES    = 8;
    localparam int         SETTLE_CYCLES   = 4;
    localparam int         RANDOM_ITEMS    = 300;
    localparam int         REPORT_LIMIT    = 10;
    localparam logic [1:0] CFG_NO_SUCH_REG = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] in_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] out_byte
    logic        m_tlast;
    logic [1:0]  m_tuser;   // [0] end_of_run, [1] bad_code_seen
    logic        cfg_wen;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0] cfg_wdata;

    // Register image kept alongside the block
    logic [31:0] desc_reg;
    logic [15:0] rec_len_reg;
    logic [15:0] rec_cnt_reg;

    // Swapper state as the block should hold it
    logic [31:0] code_shift;
    logic [15:0] byte_pos;
    logic [15:0] recs_done;
    logic [7:0]  group_hold [4];
    logic [2:0]  hold_fill;
    logic [1:0]  group_kind;
    logic        bad_flag;

    // Output bytes predicted but not yet seen on the master side, oldest first
    result_t     pending_bytes [$];
    int          mismatches;
    int          bytes_sent;
    bit          src_gaps;
    bit          sink_stalls;

    descriptor_struct_byte_swapper_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Mostly back-to-back, sometimes a short gap, now and then a long hole.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void queue_result(input logic [7:0] b, input logic eor,
                                         input logic eorun);
        result_t r;
        r.data  = b;
        r.eor   = eor;
        r.eorun = eorun;
        r.bad   = bad_flag;
        pending_bytes.push_back(r);
    endfunction

    // Advance the swapper state by one accepted byte and queue the bytes it releases.
    function automatic void reorder_byte(input logic [7:0] b);
        logic [15:0] rb;
        logic [15:0] rc;
        logic        eor;
        logic        eorun;
        logic [1:0]  code;
        int          glen;
        int          i;
        rb    = (rec_len_reg == 16'd0) ? 16'd1 : rec_len_reg;
        rc    = (rec_cnt_reg == 16'd0) ? 16'd1 : rec_cnt_reg;
        eorun = 1'b0;

        // Record start: reload the descriptor; run start also clears the sticky flag
        if (byte_pos == 16'd0) begin
            code_shift = desc_reg;
            hold_fill  = 3'd0;
            if (recs_done == 16'd0)
                bad_flag = 1'b0;
        end

        // Group start: take the next code; an invalid one kills the rest of the descriptor
        if (hold_fill == 3'd0) begin
            code = code_shift[1:0];
            if (code == CODE_BAD) begin
                bad_flag   = 1'b1;
                code_shift = '0;
                code       = CODE_PASS;
            end
            else begin
                code_shift = code_shift >> 2;
            end
            group_kind = code;
        end

        group_hold[hold_fill[1:0]] = b;
        hold_fill = hold_fill + 3'd1;
        byte_pos  = byte_pos + 16'd1;

        // Length and count compare live against the current registers
        eor = (byte_pos >= rb);
        if (eor) begin
            byte_pos  = '0;
            recs_done = recs_done + 16'd1;
            if (recs_done >= rc) begin
                eorun     = 1'b1;
                recs_done = '0;
            end
        end

        glen = (group_kind == CODE_REV4) ? 4 : 2;
        if (group_kind == CODE_PASS) begin
            queue_result(b, eor, eorun);
            if (hold_fill >= glen || eor)
                hold_fill = 3'd0;
        end
        else if (hold_fill >= glen) begin
            // Full group: release in reverse arrival order
            for (i = glen - 1; i >= 0; i--)
                queue_result(group_hold[i], (i == 0) ? eor : 1'b0, (i == 0) ? eorun : 1'b0);
            hold_fill = 3'd0;
        end
        else if (eor) begin
            // Group cut short by the record end: release unswapped
            for (i = 0; i < hold_fill; i++)
                queue_result(group_hold[i], (i == hold_fill - 1) ? eor : 1'b0,
                             (i == hold_fill - 1) ? eorun : 1'b0);
            hold_fill = 3'd0;
        end
    endfunction

    // Offer one byte on the slave side and hold it until the transfer.
    // tvalid stays high after the transfer so back-to-back bytes never toggle it.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        reorder_byte(b);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            CFG_SWAP_CODES:   desc_reg    = value;
            CFG_RECORD_BYTES: rec_len_reg = value[15:0];
            CFG_RECORD_COUNT: rec_cnt_reg = value[15:0];
            default: ;
        endcase
    endtask

    // Program all three registers, poke the unused index too, then drop the enable.
    task automatic set_format(input logic [31:0] codes, input logic [15:0] len,
                              input logic [15:0] cnt);
        write_reg(CFG_SWAP_CODES, codes);
        write_reg(CFG_RECORD_BYTES, 32'(len));
        write_reg(CFG_RECORD_COUNT, 32'(cnt));
        write_reg(CFG_NO_SUCH_REG, $urandom());
        cfg_wen <= 1'b0;
    endtask

    // Drop tvalid, wait for every predicted byte, then let any held group settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Reset values: no codes, one-byte records, one-record runs.
    task automatic test_reset_defaults();
        send_byte(8'h00);
        send_byte(8'hFF);
        drain_results();
    endtask

    // Pass, swap-two and reverse-four in one record, then descriptor runs dry.
    task automatic test_group_codes();
        logic [7:0] seq [8];
        seq = '{8'h00, 8'hFF, 8'h12, 8'h34, 8'hA5, 8'h5A, 8'h0F, 8'hF0};
        set_format(32'({CODE_REV4, CODE_SWAP2, CODE_PASS}), 16'd10, 16'd1);
        foreach (seq[k])
            send_byte(seq[k]);
        send_byte(8'h01);
        send_byte(8'h80);
        drain_results();
    endtask

    // Invalid code mid-record sets the flag; the next run starts with it clear.
    task automatic test_bad_code();
        int k;
        set_format(32'({CODE_BAD, CODE_SWAP2}), 16'd3, 16'd1);
        for (k = 0; k < 6; k++)
            send_byte(8'($urandom_range(0, 255)));
        drain_results();
    endtask

    // Reverse-four group cut off by a three-byte record.
    task automatic test_short_group();
        set_format(32'(CODE_REV4), 16'd3, 16'd1);
        send_byte(8'hC3);
        send_byte(8'h3C);
        send_byte(8'h99);
        drain_results();
    endtask

    // Zero length and count act as one.
    task automatic test_zero_sizes();
        set_format(32'(CODE_SWAP2), 16'd0, 16'd0);
        send_byte(8'h7E);
        send_byte(8'h81);
        drain_results();
    endtask

    // All-invalid descriptor with maximum sizes, then shrink the record mid-way:
    // the next byte must close both record and run.
    task automatic test_extremes_live_update();
        set_format({16{CODE_BAD}}, 16'hFFFF, 16'hFFFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        drain_results();
        set_format({16{CODE_REV4}}, 16'd2, 16'd1);
        send_byte(8'hE7);
        send_byte(8'h18);
        send_byte(8'h66);
        drain_results();
    endtask

    // Random formats; mostly whole runs with valid codes, some partial runs and bad codes.
    task automatic test_random_runs();
        logic [31:0] codes;
        logic [15:0] len;
        logic [15:0] cnt;
        logic [1:0]  code;
        int          npairs;
        int          nbytes;
        int          eff_len;
        int          eff_cnt;
        int          sent;
        int          k;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            src_gaps    = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);

            if ($urandom_range(0, 9) == 0) begin
                codes = $urandom();
            end
            else begin
                codes  = '0;
                npairs = $urandom_range(0, 7);
                for (k = 0; k < npairs; k++) begin
                    case ($urandom_range(0, 2))
                        0:       code = CODE_PASS;
                        1:       code = CODE_SWAP2;
                        default: code = CODE_REV4;
                    endcase
                    if ($urandom_range(0, 19) == 0)
                        code = CODE_BAD;
                    codes[2*k +: 2] = code;
                end
            end

            k = $urandom_range(0, 99);
            if (k < 3)
                len = '0;
            else if (k < 85)
                len = 16'($urandom_range(1, 12));
            else
                len = 16'($urandom_range(13, 40));
            cnt = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 4));

            eff_len = (len == 16'd0) ? 1 : len;
            eff_cnt = (cnt == 16'd0) ? 1 : cnt;
            if ($urandom_range(0, 4) == 0)
                nbytes = $urandom_range(1, 2 * eff_len);
            else
                nbytes = eff_len * eff_cnt;

            set_format(codes, len, cnt);
            for (k = 0; k < nbytes; k++)
                send_byte(8'($urandom_range(0, 255)));
            sent += nbytes;
            drain_results();
        end
    endtask

    // Master-side pacing: ready runs of random length broken by stalls.
    initial begin : sink_pacing
        int len;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (!sink_stalls) begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else begin
                len = pick_gap();
                if (len > 0) begin
                    m_tready <= 1'b0;
                    repeat (len) @(posedge clk);
                end
                m_tready <= 1'b1;
                len = $urandom_range(1, 12);
                repeat (len) @(posedge clk);
            end
        end
    end

    // Compare every master-side transfer with the oldest predicted byte.
    always @(posedge clk) begin : check_output
        result_t seen;
        result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            seen.data  = m_tdata;
            seen.eor   = m_tlast;
            seen.eorun = m_tuser[0];
            seen.bad   = m_tuser[1];
            if (pending_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected transfer: data %h last %b user %b",
                             m_tdata, m_tlast, m_tuser);
            end
            else begin
                want = pending_bytes.pop_front();
                if (seen.data !== want.data || seen.eor !== want.eor ||
                    seen.eorun !== want.eorun || seen.bad !== want.bad) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch: data %h/%h eor %b/%b eorun %b/%b bad %b/%b (exp/act)",
                                 want.data, seen.data, want.eor, seen.eor,
                                 want.eorun, seen.eorun, want.bad, seen.bad);
                end
            end
        end
    end

    initial begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wen   <= 1'b0;
        cfg_index <= CFG_SWAP_CODES;
        cfg_wdata <= '0;
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        mismatches  = 0;
        bytes_sent  = 0;

        // Hold the prediction at its reset state
        desc_reg    = '0;
        rec_len_reg = 16'd1;
        rec_cnt_reg = 16'd1;
        code_shift  = '0;
        byte_pos    = '0;
        recs_done   = '0;
        hold_fill   = '0;
        group_kind  = CODE_PASS;
        bad_flag    = 1'b0;
        foreach (group_hold[k])
            group_hold[k] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_group_codes();
        test_bad_code();
        sink_stalls = 1'b0;
        test_short_group();
        test_zero_sizes();
        sink_stalls = 1'b1;
        test_extremes_live_update();
        test_random_runs();

        drain_results();
        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
